/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL that carries checks.
// No dependencies; pulled in by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define C2LE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication under an active-low reset.
`define C2LE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/c2le_pkg.sv */
// Shared types and constants of the 2-D convolution engine.
// Used by the controller, the datapath and the top level; no dependencies.
package c2le_pkg;

    // Default store dimensions
    localparam int C2LE_MAX_HEIGHT       = 32;
    localparam int C2LE_MAX_WIDTH        = 32;
    localparam int C2LE_MAX_IN_CHANNELS  = 8;
    localparam int C2LE_MAX_OUT_CHANNELS = 8;
    localparam int C2LE_MAX_KERNEL       = 5;

    // Field and register widths
    localparam int CMD_W      = 2;
    localparam int FCH_W      = 3;
    localparam int FPOS_W     = 5;
    localparam int VALUE_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int HEIGHT_W   = 6;
    localparam int CH_W       = 4;
    localparam int K_W        = 3;
    localparam int STRIDE_W   = 2;
    localparam int PAD_W      = 3;
    localparam int SPAN_W     = 8;
    localparam int POS_W      = 9;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 6;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    // Register reset values
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT   = 6'd32;
    localparam logic [HEIGHT_W-1:0] RST_WIDTH    = 6'd32;
    localparam logic [CH_W-1:0]     RST_IN_CH    = 4'd1;
    localparam logic [CH_W-1:0]     RST_OUT_CH   = 4'd1;
    localparam logic [K_W-1:0]      RST_KERNEL   = 3'd3;
    localparam logic [STRIDE_W-1:0] RST_STRIDE   = 2'd1;
    localparam logic [PAD_W-1:0]    RST_PAD      = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SAMPLE = 2'd0,
        CMD_LOAD_WEIGHT = 2'd1,
        CMD_LOAD_BIAS   = 2'd2,
        CMD_COMPUTE     = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INPUT_HEIGHT = 3'd0,
        REG_INPUT_WIDTH  = 3'd1,
        REG_IN_CHANNELS  = 3'd2,
        REG_OUT_CHANNELS = 3'd3,
        REG_KERNEL_SIZE  = 3'd4,
        REG_STRIDE       = 3'd5,
        REG_PAD_SIZE     = 3'd6,
        REG_USE_BIAS     = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WRITE,
        ST_CHECK,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT,
        ST_REJECT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_addr;
        logic load_write;
        logic start;
        logic step;
        logic next_oc;
        logic emit;
        logic reject;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_ok;
        logic tap_last;
        logic pipe_busy;
        logic out_full;
        logic oc_last;
    } dp_status_t;

endpackage

/* rtl/core/conv2d_layer_engine_unit.sv */
// Direct 2-D convolution engine (NCHW, one image) with config and stream ports.
// Depends on c2le_pkg, c2le_ctrl, c2le_datapath and assert_macros.svh.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the eight
//    layer registers; always ready, write it only while the engine is idle.
//  - Slave stream: tuser is the command (load sample, load weight, load bias,
//    compute). tdata carries channel, sub_channel, row, col and value.
//  - A load passes through the LOAD and WRITE states before the next request is taken.
//  - A compute request gives out_channels results on the master stream, one
//    per output channel in order, tlast on the final one. A rejected request
//    (bad dimensions or position outside the output) gives one zero result
//    with tuser set and tlast set.
//  - Compute uses a single multiply-accumulate pipeline that walks one tap per cycle
//    off one read port of each store, then drains 4 stages before each result.
//  - The result register holds a result until m_tready; while it is full the
//    engine waits before loading the next result; requests are taken only in IDLE.
//  - Reset restores the register defaults; the stores hold nothing defined until
//    written, and no clearing pass runs.
`include "assert_macros.svh"

module conv2d_layer_engine_unit
    import c2le_pkg::*;
#(
    parameter int MAX_HEIGHT       = C2LE_MAX_HEIGHT,
    parameter int MAX_WIDTH        = C2LE_MAX_WIDTH,
    parameter int MAX_IN_CHANNELS  = C2LE_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = C2LE_MAX_OUT_CHANNELS,
    parameter int MAX_KERNEL       = C2LE_MAX_KERNEL
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // channel[2:0], sub_channel[5:3], row[10:6], col[15:11], value[47:16]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]       s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // result[31:0], out_channel[34:32], out_row[39:35], out_col[44:40], zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    // out_of_range
    output logic                   m_tuser,
    output logic                   m_tlast
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    c2le_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    c2le_datapath #(
        .MAX_HEIGHT       (MAX_HEIGHT),
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
        .MAX_KERNEL       (MAX_KERNEL)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    // A result is only written into an empty result register
    `C2LE_ASSERT_IMPLY(a_emit_into_empty, clk, rst_n, dp_cmd.emit || dp_cmd.reject, !dp_status.out_full)

    // A rejected request's result always carries tlast
    `C2LE_ASSERT_IMPLY(a_reject_is_last, clk, rst_n, m_tvalid && m_tuser, m_tlast)

    // Taps are only issued once the request is in hand
    `C2LE_ASSERT_IMPLY(a_step_not_idle, clk, rst_n, dp_cmd.step || dp_cmd.start, !s_tready)

    // An accepted request takes the engine out of IDLE, so s_tready falls
    `C2LE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

/* rtl/core/c2le_ctrl.sv */
// Sequencer of the convolution engine: request intake, loads, tap walk, drain, emit, reject.
// Depends on c2le_pkg; drives the datapath by dp_cmd_t, watches dp_status_t.
module c2le_ctrl
    import c2le_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic [CMD_W-1:0] s_tuser,
    output logic             s_tready,
    output dp_cmd_t          cmd,
    input  dp_status_t       status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == CMD_COMPUTE) ? ST_CHECK : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_IDLE;
            ST_CHECK:  state_next = status.req_ok ? ST_WALK : ST_REJECT;
            ST_WALK:
            begin
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    state_next = status.oc_last ? ST_IDLE : ST_WALK;
                end
            end
            ST_REJECT:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD:   cmd.load_addr  = 1'b1;
            ST_WRITE:  cmd.load_write = 1'b1;
            ST_CHECK:  cmd.start      = status.req_ok;
            ST_WALK:   cmd.step       = 1'b1;
            ST_DRAIN:  cmd            = '0;
            ST_EMIT:
            begin
                cmd.emit    = !status.out_full;
                cmd.next_oc = !status.out_full && !status.oc_last;
            end
            ST_REJECT: cmd.reject = !status.out_full;
            default:   cmd        = '0;
        endcase
    end

endmodule

/* rtl/core/c2le_datapath.sv */
// Datapath of the convolution engine: config registers, the three stores,
// the tap counters, the multiply-accumulate pipeline and the result register.
// Depends on c2le_pkg; sequenced by c2le_ctrl.
module c2le_datapath
    import c2le_pkg::*;
#(
    parameter int MAX_HEIGHT       = C2LE_MAX_HEIGHT,
    parameter int MAX_WIDTH        = C2LE_MAX_WIDTH,
    parameter int MAX_IN_CHANNELS  = C2LE_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = C2LE_MAX_OUT_CHANNELS,
    parameter int MAX_KERNEL       = C2LE_MAX_KERNEL
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [CMD_W-1:0]       s_tuser,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast,
    input  dp_cmd_t                cmd,
    output dp_status_t             status
);

    localparam int S_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int S_AW    = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int B_AW    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int PLANE   = MAX_HEIGHT * MAX_WIDTH;
    localparam int KK      = MAX_KERNEL * MAX_KERNEL;
    localparam int W_OC_STRIDE = MAX_IN_CHANNELS * KK;

    function automatic logic signed [SAMPLE_W-1:0] sat_q88(input logic signed [VALUE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 32'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -32'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_q1616(input logic signed [ACC_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if ((&v[ACC_W-1:VALUE_W-1]) || !(|v[ACC_W-1:VALUE_W-1]))
        begin
            r = v[VALUE_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Configuration
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] width_reg;
    logic [CH_W-1:0]     in_ch_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [K_W-1:0]      ksize_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [PAD_W-1:0]    pad_reg;
    logic                use_bias_reg;

    // Captured request
    cmd_t                     req_cmd_reg;
    logic [FCH_W-1:0]         req_ch_reg;
    logic [FCH_W-1:0]         req_sub_reg;
    logic [FPOS_W-1:0]        req_row_reg;
    logic [FPOS_W-1:0]        req_col_reg;
    logic signed [VALUE_W-1:0] req_value_reg;

    // Load path
    logic                       ld_s_en_reg;
    logic                       ld_w_en_reg;
    logic                       ld_b_en_reg;
    logic [S_AW-1:0]            ld_s_addr_reg;
    logic [W_AW-1:0]            ld_w_addr_reg;
    logic [B_AW-1:0]            ld_b_addr_reg;
    logic signed [SAMPLE_W-1:0] ld_data_reg;

    // Stores
    logic signed [SAMPLE_W-1:0] sample_mem [S_DEPTH];
    logic signed [SAMPLE_W-1:0] weight_mem [W_DEPTH];
    logic signed [VALUE_W-1:0]  bias_mem   [MAX_OUT_CHANNELS];

    // Tap counters
    logic [CH_W-1:0] oc_reg;
    logic [CH_W-1:0] ic_reg;
    logic [K_W-1:0]  kh_reg;
    logic [K_W-1:0]  kw_reg;
    logic            kw_end;
    logic            kh_end;

    // Request check
    logic              stride_two;
    logic              dims_ok;
    logic [SPAN_W-1:0] span_h;
    logic [SPAN_W-1:0] span_w;
    logic [SPAN_W-1:0] num_h;
    logic [SPAN_W-1:0] num_w;
    logic [FPOS_W:0]   row_s;
    logic [FPOS_W:0]   col_s;

    // Pipeline
    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic                       ok2_reg, ok3_reg;
    logic signed [POS_W-1:0]    hp1_reg, wp1_reg;
    logic [CH_W-1:0]            ic1_reg;
    logic [K_W-1:0]             kh1_reg, kw1_reg;
    logic [S_AW-1:0]            s_addr2_reg;
    logic [W_AW-1:0]            w_addr2_reg;
    logic signed [SAMPLE_W-1:0] s_rd_reg, w_rd_reg;
    logic signed [PROD_W-1:0]   prod4_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [VALUE_W-1:0]  bias_rd_reg;
    logic signed [ACC_W-1:0]    sum;
    logic signed [POS_W-1:0]    hp_tap, wp_tap;
    logic                       hp_ok, wp_ok;

    // Result register
    logic                       out_full_reg;
    logic signed [VALUE_W-1:0]  out_result_reg;
    logic [FCH_W-1:0]           out_channel_reg;
    logic [FPOS_W-1:0]          out_row_reg;
    logic [FPOS_W-1:0]          out_col_reg;
    logic                       out_oor_reg;
    logic                       out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg   <= RST_HEIGHT;
            width_reg    <= RST_WIDTH;
            in_ch_reg    <= RST_IN_CH;
            out_ch_reg   <= RST_OUT_CH;
            ksize_reg    <= RST_KERNEL;
            stride_reg   <= RST_STRIDE;
            pad_reg      <= RST_PAD;
            use_bias_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INPUT_HEIGHT: height_reg   <= cfg_data[HEIGHT_W-1:0];
                REG_INPUT_WIDTH:  width_reg    <= cfg_data[HEIGHT_W-1:0];
                REG_IN_CHANNELS:  in_ch_reg    <= cfg_data[CH_W-1:0];
                REG_OUT_CHANNELS: out_ch_reg   <= cfg_data[CH_W-1:0];
                REG_KERNEL_SIZE:  ksize_reg    <= cfg_data[K_W-1:0];
                REG_STRIDE:       stride_reg   <= cfg_data[STRIDE_W-1:0];
                REG_PAD_SIZE:     pad_reg      <= cfg_data[PAD_W-1:0];
                REG_USE_BIAS:     use_bias_reg <= cfg_data[0];
                default:          use_bias_reg <= use_bias_reg;
            endcase
        end
    end

    // s_tdata: channel, sub_channel, row, col, value from bit 0 up
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_cmd_reg   <= cmd_t'(s_tuser);
            req_ch_reg    <= s_tdata[2:0];
            req_sub_reg   <= s_tdata[5:3];
            req_row_reg   <= s_tdata[10:6];
            req_col_reg   <= s_tdata[15:11];
            req_value_reg <= s_tdata[47:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_addr)
        begin
            ld_s_en_reg <= (req_cmd_reg == CMD_LOAD_SAMPLE)
                        && (int'(req_ch_reg) < MAX_IN_CHANNELS)
                        && (int'(req_row_reg) < MAX_HEIGHT)
                        && (int'(req_col_reg) < MAX_WIDTH);
            ld_w_en_reg <= (req_cmd_reg == CMD_LOAD_WEIGHT)
                        && (int'(req_ch_reg) < MAX_OUT_CHANNELS)
                        && (int'(req_sub_reg) < MAX_IN_CHANNELS)
                        && (int'(req_row_reg) < MAX_KERNEL)
                        && (int'(req_col_reg) < MAX_KERNEL);
            ld_b_en_reg <= (req_cmd_reg == CMD_LOAD_BIAS)
                        && (int'(req_ch_reg) < MAX_OUT_CHANNELS);
            ld_s_addr_reg <= S_AW'(int'(req_ch_reg) * PLANE
                                   + int'(req_row_reg) * MAX_WIDTH + int'(req_col_reg));
            ld_w_addr_reg <= W_AW'(int'(req_ch_reg) * W_OC_STRIDE + int'(req_sub_reg) * KK
                                   + int'(req_row_reg) * MAX_KERNEL + int'(req_col_reg));
            ld_b_addr_reg <= B_AW'(req_ch_reg);
            ld_data_reg   <= sat_q88(req_value_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write && ld_s_en_reg)
        begin
            sample_mem[ld_s_addr_reg] <= ld_data_reg;
        end
        s_rd_reg <= sample_mem[s_addr2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write && ld_w_en_reg)
        begin
            weight_mem[ld_w_addr_reg] <= ld_data_reg;
        end
        w_rd_reg <= weight_mem[w_addr2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write && ld_b_en_reg)
        begin
            bias_mem[ld_b_addr_reg] <= req_value_reg;
        end
        bias_rd_reg <= bias_mem[B_AW'(oc_reg)];
    end

    // Output extent check: position valid when pos*stride <= in + 2*pad - k, stride 3 counting as 2
    assign stride_two = (stride_reg >= 2'd2);
    assign row_s  = stride_two ? {req_row_reg, 1'b0} : {1'b0, req_row_reg};
    assign col_s  = stride_two ? {req_col_reg, 1'b0} : {1'b0, req_col_reg};
    assign span_h = SPAN_W'(height_reg) + SPAN_W'({pad_reg, 1'b0});
    assign span_w = SPAN_W'(width_reg) + SPAN_W'({pad_reg, 1'b0});
    assign num_h  = span_h - SPAN_W'(ksize_reg);
    assign num_w  = span_w - SPAN_W'(ksize_reg);
    assign dims_ok = (height_reg != '0) && (int'(height_reg) <= MAX_HEIGHT)
                  && (width_reg != '0) && (int'(width_reg) <= MAX_WIDTH)
                  && (in_ch_reg != '0) && (int'(in_ch_reg) <= MAX_IN_CHANNELS)
                  && (out_ch_reg != '0) && (int'(out_ch_reg) <= MAX_OUT_CHANNELS)
                  && (ksize_reg != '0) && (int'(ksize_reg) <= MAX_KERNEL)
                  && (stride_reg != '0)
                  && (span_h >= SPAN_W'(ksize_reg)) && (span_w >= SPAN_W'(ksize_reg));

    assign status.req_ok = dims_ok && (SPAN_W'(row_s) <= num_h) && (SPAN_W'(col_s) <= num_w);

    assign kw_end = (kw_reg == ksize_reg - 3'd1);
    assign kh_end = (kh_reg == ksize_reg - 3'd1);
    assign status.tap_last  = (ic_reg == in_ch_reg - 4'd1) && kh_end && kw_end;
    assign status.oc_last   = (oc_reg == out_ch_reg - 4'd1);
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign status.out_full  = out_full_reg;

    // Walk kw fastest, then kh, then input channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_reg <= '0;
            ic_reg <= '0;
            kh_reg <= '0;
            kw_reg <= '0;
        end
        else if (cmd.start || cmd.next_oc)
        begin
            oc_reg <= cmd.start ? '0 : oc_reg + 4'd1;
            ic_reg <= '0;
            kh_reg <= '0;
            kw_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (kw_end)
            begin
                kw_reg <= '0;
                if (kh_end)
                begin
                    kh_reg <= '0;
                    ic_reg <= ic_reg + 4'd1;
                end
                else
                begin
                    kh_reg <= kh_reg + 3'd1;
                end
            end
            else
            begin
                kw_reg <= kw_reg + 3'd1;
            end
        end
    end

    assign hp_tap = $signed(POS_W'(row_s)) + $signed(POS_W'(kh_reg)) - $signed(POS_W'(pad_reg));
    assign wp_tap = $signed(POS_W'(col_s)) + $signed(POS_W'(kw_reg)) - $signed(POS_W'(pad_reg));
    assign hp_ok  = !hp1_reg[POS_W-1] && (hp1_reg[POS_W-2:0] < (POS_W-1)'(height_reg));
    assign wp_ok  = !wp1_reg[POS_W-1] && (wp1_reg[POS_W-2:0] < (POS_W-1)'(width_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hp1_reg <= hp_tap;
        wp1_reg <= wp_tap;
        ic1_reg <= ic_reg;
        kh1_reg <= kh_reg;
        kw1_reg <= kw_reg;

        // Padding taps read anything and are dropped at the multiplier
        ok2_reg     <= hp_ok && wp_ok;
        s_addr2_reg <= S_AW'(int'(ic1_reg) * PLANE + int'(hp1_reg) * MAX_WIDTH + int'(wp1_reg));
        w_addr2_reg <= W_AW'(int'(oc_reg) * W_OC_STRIDE + int'(ic1_reg) * KK
                             + int'(kh1_reg) * MAX_KERNEL + int'(kw1_reg));

        ok3_reg <= ok2_reg;

        if (ok3_reg)
        begin
            prod4_reg <= s_rd_reg * w_rd_reg;
        end
        else
        begin
            prod4_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start || cmd.next_oc)
        begin
            acc_reg <= '0;
        end
        else if (v4_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod4_reg);
        end
    end

    assign sum = acc_reg + (use_bias_reg ? ACC_W'(bias_rd_reg) : 48'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.reject)
        begin
            out_full_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_result_reg  <= sat_q1616(sum);
            out_channel_reg <= FCH_W'(oc_reg);
            out_row_reg     <= req_row_reg;
            out_col_reg     <= req_col_reg;
            out_oor_reg     <= 1'b0;
            out_last_reg    <= status.oc_last;
        end
        else if (cmd.reject)
        begin
            out_result_reg  <= '0;
            out_channel_reg <= '0;
            out_row_reg     <= req_row_reg;
            out_col_reg     <= req_col_reg;
            out_oor_reg     <= 1'b1;
            out_last_reg    <= 1'b1;
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {3'b000, out_col_reg, out_row_reg, out_channel_reg, out_result_reg};
    assign m_tuser  = out_oor_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* sim/conv2d_layer_engine_unit_tb.sv */
// Self-checking bench for conv2d_layer_engine_unit: loads stores, runs computes, checks sums.
// Depends on c2le_pkg and the engine RTL; keeps its own model of the stores and registers.
module conv2d_layer_engine_unit_tb;
    import c2le_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 30;

    typedef struct {
        logic [31:0] sum;
        logic [2:0]  oc;
        logic [4:0]  orow;
        logic [4:0]  ocol;
        logic        oor;
        logic        last;
    } conv_sum_t;

    // Mirror of the engine: stores, layer registers and the sums still owed.
    class conv_sum_board;
        logic signed [SAMPLE_W-1:0] pixel_mem
            [C2LE_MAX_IN_CHANNELS][C2LE_MAX_HEIGHT][C2LE_MAX_WIDTH];
        bit pixel_set [C2LE_MAX_IN_CHANNELS][C2LE_MAX_HEIGHT][C2LE_MAX_WIDTH];
        logic signed [SAMPLE_W-1:0] weight_mem
            [C2LE_MAX_OUT_CHANNELS][C2LE_MAX_IN_CHANNELS][C2LE_MAX_KERNEL][C2LE_MAX_KERNEL];
        bit weight_set
            [C2LE_MAX_OUT_CHANNELS][C2LE_MAX_IN_CHANNELS][C2LE_MAX_KERNEL][C2LE_MAX_KERNEL];
        logic signed [VALUE_W-1:0] bias_mem [C2LE_MAX_OUT_CHANNELS];
        bit bias_set [C2LE_MAX_OUT_CHANNELS];

        logic [HEIGHT_W-1:0] height;
        logic [HEIGHT_W-1:0] width;
        logic [CH_W-1:0]     in_ch;
        logic [CH_W-1:0]     out_ch;
        logic [K_W-1:0]      ksize;
        logic [STRIDE_W-1:0] step;
        logic [PAD_W-1:0]    pad;
        logic                bias_on;

        conv_sum_t   pending_sums [$];
        int unsigned errors;

        function new();
            height  = RST_HEIGHT;
            width   = RST_WIDTH;
            in_ch   = RST_IN_CH;
            out_ch  = RST_OUT_CH;
            ksize   = RST_KERNEL;
            step    = RST_STRIDE;
            pad     = RST_PAD;
            bias_on = 1'b0;
            errors  = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_INPUT_HEIGHT: height  = val[HEIGHT_W-1:0];
                REG_INPUT_WIDTH:  width   = val[HEIGHT_W-1:0];
                REG_IN_CHANNELS:  in_ch   = val[CH_W-1:0];
                REG_OUT_CHANNELS: out_ch  = val[CH_W-1:0];
                REG_KERNEL_SIZE:  ksize   = val[K_W-1:0];
                REG_STRIDE:       step    = val[STRIDE_W-1:0];
                REG_PAD_SIZE:     pad     = val[PAD_W-1:0];
                REG_USE_BIAS:     bias_on = val[0];
                default: ;
            endcase
        endfunction

        function int eff_step();
            return (step > 2) ? 2 : int'(step);
        endfunction

        // Output extent along one axis; zero when the layer shape is unusable.
        function int out_size(bit rows);
            int h, w, k, p, s;
            h = height;
            w = width;
            k = ksize;
            p = pad;
            s = eff_step();
            if (h < 1 || h > C2LE_MAX_HEIGHT || w < 1 || w > C2LE_MAX_WIDTH) return 0;
            if (in_ch < 1 || in_ch > C2LE_MAX_IN_CHANNELS) return 0;
            if (out_ch < 1 || out_ch > C2LE_MAX_OUT_CHANNELS) return 0;
            if (k < 1 || k > C2LE_MAX_KERNEL || s < 1) return 0;
            if (h + 2 * p < k || w + 2 * p < k) return 0;
            return ((rows ? h : w) - k + 2 * p) / s + 1;
        endfunction

        function bit position_ok(int row, int col);
            return row < out_size(1) && col < out_size(0);
        endfunction

        function logic signed [15:0] clamp16(logic signed [31:0] v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function logic [31:0] clamp32(longint a);
            if (a > 64'sd2147483647) return 32'h7fffffff;
            if (a < -64'sd2147483648) return 32'h80000000;
            return a[31:0];
        endfunction

        function void note_request(cmd_t cmd, int ch, int sub, int row, int col,
                                   logic signed [31:0] value);
            conv_sum_t r;
            longint acc;
            int s, h, w, k, p, nic, noc, hp, wp;
            case (cmd)
                CMD_LOAD_SAMPLE: begin
                    pixel_mem[ch][row][col] = clamp16(value);
                    pixel_set[ch][row][col] = 1'b1;
                end
                CMD_LOAD_WEIGHT: begin
                    // taps beyond the kernel store are dropped
                    if (row < C2LE_MAX_KERNEL && col < C2LE_MAX_KERNEL) begin
                        weight_mem[ch][sub][row][col] = clamp16(value);
                        weight_set[ch][sub][row][col] = 1'b1;
                    end
                end
                CMD_LOAD_BIAS: begin
                    bias_mem[ch] = value;
                    bias_set[ch] = 1'b1;
                end
                default: begin
                    r.orow = row;
                    r.ocol = col;
                    if (!position_ok(row, col)) begin
                        r.sum  = '0;
                        r.oc   = '0;
                        r.oor  = 1'b1;
                        r.last = 1'b1;
                        pending_sums.push_back(r);
                    end else begin
                        s = eff_step();
                        h = height;
                        w = width;
                        k = ksize;
                        p = pad;
                        nic = in_ch;
                        noc = out_ch;
                        for (int oc = 0; oc < noc; oc++) begin
                            acc = 0;
                            for (int ic = 0; ic < nic; ic++)
                                for (int kh = 0; kh < k; kh++) begin
                                    hp = row * s + kh - p;
                                    if (hp < 0 || hp >= h) continue;
                                    for (int kw = 0; kw < k; kw++) begin
                                        wp = col * s + kw - p;
                                        if (wp < 0 || wp >= w) continue;
                                        acc += longint'(weight_mem[oc][ic][kh][kw])
                                             * longint'(pixel_mem[ic][hp][wp]);
                                    end
                                end
                            if (bias_on) acc += longint'(bias_mem[oc]);
                            r.sum  = clamp32(acc);
                            r.oc   = oc;
                            r.oor  = 1'b0;
                            r.last = (oc == noc - 1);
                            pending_sums.push_back(r);
                        end
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic flag, logic tail);
            conv_sum_t want;
            if (pending_sums.size() == 0) begin
                $error("result with none pending: tdata %h tuser %b tlast %b",
                       data, flag, tail);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            check_field("result", want.sum, data[31:0]);
            check_field("out_channel", want.oc, data[34:32]);
            check_field("out_row", want.orow, data[39:35]);
            check_field("out_col", want.ocol, data[44:40]);
            check_field("out_of_range", want.oor, flag);
            check_field("last", want.last, tail);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // channel[2:0], sub_channel[5:3], row[10:6], col[15:11], value[47:16]
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // command[1:0]
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // result[31:0], out_channel[34:32], out_row[39:35], out_col[44:40], zero fill
    logic [M_TDATA_W-1:0]   m_tdata;
    // out_of_range
    logic                   m_tuser;
    logic                   m_tlast;

    conv_sum_board sb;
    int sent_items = 0;
    int gap_pct = 10;
    int stall_pct = 10;
    bit quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    conv2d_layer_engine_unit dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk) begin
        if (quiet) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int span(int v, int mx);
        return (v >= 1 && v <= mx) ? v : mx;
    endfunction

    function automatic logic [31:0] rand_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return $urandom_range(8191) - 4096;
        if (pick < 85) return $urandom;
        case ($urandom_range(4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00007fff;
            3: return 32'hffff8000;
            default: return 32'h0;
        endcase
    endfunction

    task automatic send_request(cmd_t cmd, int ch, int sub, int row, int col,
                                logic [31:0] value);
        if (!quiet && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, col[4:0], row[4:0], sub[2:0], ch[2:0]};
        do @(posedge clk); while (!s_tready);
        sb.note_request(cmd, ch, sub, row, col, value);
        sent_items++;
    endtask

    // Drop valid, wait out every owed result, then let load writes finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic set_layer(int h, int w, int ic, int oc, int k, int st, int p, int b);
        write_reg(REG_INPUT_HEIGHT, h);
        write_reg(REG_INPUT_WIDTH, w);
        write_reg(REG_IN_CHANNELS, ic);
        write_reg(REG_OUT_CHANNELS, oc);
        write_reg(REG_KERNEL_SIZE, k);
        write_reg(REG_STRIDE, st);
        write_reg(REG_PAD_SIZE, p);
        write_reg(REG_USE_BIAS, b);
        cfg_valid <= 1'b0;
    endtask

    // Load every store entry that a compute at this position reads and nobody wrote yet.
    task automatic fill_window(int row, int col);
        int s, h, w, k, p, nic, noc, hp, wp;
        s = sb.eff_step();
        h = sb.height;
        w = sb.width;
        k = sb.ksize;
        p = sb.pad;
        nic = sb.in_ch;
        noc = sb.out_ch;
        for (int ic = 0; ic < nic; ic++)
            for (int kh = 0; kh < k; kh++) begin
                hp = row * s + kh - p;
                if (hp < 0 || hp >= h) continue;
                for (int kw = 0; kw < k; kw++) begin
                    wp = col * s + kw - p;
                    if (wp < 0 || wp >= w) continue;
                    if (!sb.pixel_set[ic][hp][wp])
                        send_request(CMD_LOAD_SAMPLE, ic, $urandom_range(7), hp, wp,
                                     rand_value());
                    for (int oc = 0; oc < noc; oc++)
                        if (!sb.weight_set[oc][ic][kh][kw])
                            send_request(CMD_LOAD_WEIGHT, oc, ic, kh, kw, rand_value());
                end
            end
        if (sb.bias_on)
            for (int oc = 0; oc < noc; oc++)
                if (!sb.bias_set[oc])
                    send_request(CMD_LOAD_BIAS, oc, $urandom_range(7), $urandom_range(31),
                                 $urandom_range(31), rand_value());
    endtask

    task automatic random_request();
        int pick, oh, ow, row, col, ch, sub;
        pick = $urandom_range(99);
        oh = sb.out_size(1);
        ow = sb.out_size(0);
        if (pick < 45) begin
            if (oh > 0 && $urandom_range(4) != 0) begin
                row = $urandom_range(span(oh, 32) - 1);
                col = $urandom_range(span(ow, 32) - 1);
            end else begin
                row = $urandom_range(31);
                col = $urandom_range(31);
            end
            if (sb.position_ok(row, col)) fill_window(row, col);
            send_request(CMD_COMPUTE, $urandom_range(7), $urandom_range(7), row, col, $urandom);
        end else if (pick < 70) begin
            if ($urandom_range(9) == 0) begin
                ch  = $urandom_range(7);
                row = $urandom_range(31);
                col = $urandom_range(31);
            end else begin
                ch  = $urandom_range(span(sb.in_ch, C2LE_MAX_IN_CHANNELS) - 1);
                row = $urandom_range(span(sb.height, C2LE_MAX_HEIGHT) - 1);
                col = $urandom_range(span(sb.width, C2LE_MAX_WIDTH) - 1);
            end
            send_request(CMD_LOAD_SAMPLE, ch, $urandom_range(7), row, col, rand_value());
        end else if (pick < 90) begin
            if ($urandom_range(9) == 0) begin
                ch  = $urandom_range(7);
                sub = $urandom_range(7);
                row = $urandom_range(31);
                col = $urandom_range(31);
            end else begin
                ch  = $urandom_range(span(sb.out_ch, C2LE_MAX_OUT_CHANNELS) - 1);
                sub = $urandom_range(span(sb.in_ch, C2LE_MAX_IN_CHANNELS) - 1);
                row = $urandom_range(span(sb.ksize, C2LE_MAX_KERNEL) - 1);
                col = $urandom_range(span(sb.ksize, C2LE_MAX_KERNEL) - 1);
            end
            send_request(CMD_LOAD_WEIGHT, ch, sub, row, col, rand_value());
        end else begin
            ch = ($urandom_range(4) == 0) ? $urandom_range(7)
                                          : $urandom_range(span(sb.out_ch, 8) - 1);
            send_request(CMD_LOAD_BIAS, ch, $urandom_range(7), $urandom_range(31),
                         $urandom_range(31), ($urandom_range(1) != 0) ? $urandom : rand_value());
        end
    endtask

    task automatic run_phase(int h, int w, int ic, int oc, int k, int st, int p, int b);
        int stop;
        wait_idle();
        set_layer(h, w, ic, oc, k, st, p, b);
        gap_pct   = $urandom_range(2) * 12;
        stall_pct = $urandom_range(2) * 12;
        stop = sent_items + PHASE_ITEMS;
        while (sent_items < stop) random_request();
    endtask

    task automatic small_phase();
        run_phase($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(3, 1),
                  $urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(3, 1),
                  $urandom_range(3), $urandom_range(1));
    endtask

    // Small layer with a register out of range, a kernel past the padded input, or deep padding.
    task automatic odd_layer_phase();
        int h, w, ic, oc, k, st, p;
        h  = $urandom_range(8, 1);
        w  = $urandom_range(8, 1);
        ic = $urandom_range(3, 1);
        oc = $urandom_range(4, 1);
        k  = $urandom_range(4, 1);
        st = $urandom_range(3, 1);
        p  = $urandom_range(2);
        case ($urandom_range(9))
            0: h = 0;
            1: h = $urandom_range(63, 33);
            2: w = 0;
            3: w = $urandom_range(63, 33);
            4: ic = ($urandom_range(1) != 0) ? 0 : $urandom_range(15, 9);
            5: oc = ($urandom_range(1) != 0) ? 0 : $urandom_range(15, 9);
            6: k = ($urandom_range(2) == 0) ? 0 : $urandom_range(7, 6);
            7: st = 0;
            8: begin
                h = 1;
                k = 5;
                p = 1;
            end
            default: p = 7;
        endcase
        run_phase(h, w, ic, oc, k, st, p, $urandom_range(1));
    endtask

    task automatic directed_checks();
        // reset layer is 32x32 with a 3x3 kernel, so output rows stop at 29
        send_request(CMD_COMPUTE, 0, 0, 30, 0, 32'h0);
        send_request(CMD_COMPUTE, 7, 7, 31, 31, 32'hffffffff);
        wait_idle();
        // stride 3 acts as 2; pad 1 puts part of every window in the border
        set_layer(2, 3, 1, 2, 2, 3, 1, 1);
        send_request(CMD_LOAD_SAMPLE, 0, 0, 0, 0, 32'h7fffffff);
        send_request(CMD_LOAD_SAMPLE, 0, 0, 0, 1, 32'h80000000);
        send_request(CMD_LOAD_SAMPLE, 0, 0, 0, 2, 32'h00007fff);
        send_request(CMD_LOAD_SAMPLE, 0, 0, 1, 0, 32'hffff8000);
        send_request(CMD_LOAD_SAMPLE, 0, 0, 1, 1, 32'h00012345);
        send_request(CMD_LOAD_SAMPLE, 0, 0, 1, 2, 32'hffffffff);
        send_request(CMD_LOAD_SAMPLE, 7, 7, 31, 31, 32'h0);
        send_request(CMD_LOAD_WEIGHT, 0, 0, 0, 0, 32'h00007fff);
        send_request(CMD_LOAD_WEIGHT, 0, 0, 0, 1, 32'h00007fff);
        send_request(CMD_LOAD_WEIGHT, 0, 0, 1, 0, 32'hffffffff);
        send_request(CMD_LOAD_WEIGHT, 0, 0, 1, 1, 32'h80000000);
        send_request(CMD_LOAD_WEIGHT, 1, 0, 0, 0, 32'hffff8000);
        send_request(CMD_LOAD_WEIGHT, 1, 0, 0, 1, 32'hffff8000);
        send_request(CMD_LOAD_WEIGHT, 1, 0, 1, 0, 32'h00000001);
        send_request(CMD_LOAD_WEIGHT, 1, 0, 1, 1, 32'h7fffffff);
        send_request(CMD_LOAD_WEIGHT, 7, 7, 31, 31, 32'h12345678);
        send_request(CMD_LOAD_BIAS, 0, 0, 0, 0, 32'h7fffffff);
        send_request(CMD_LOAD_BIAS, 1, 0, 0, 0, 32'h80000000);
        send_request(CMD_COMPUTE, 0, 0, 0, 0, 32'h0);
        send_request(CMD_COMPUTE, 0, 0, 1, 1, 32'h0);
        send_request(CMD_COMPUTE, 0, 0, 2, 0, 32'h0);
        send_request(CMD_COMPUTE, 0, 0, 0, 31, 32'h0);
        wait_idle();
        write_reg(REG_KERNEL_SIZE, 6);
        cfg_valid <= 1'b0;
        send_request(CMD_COMPUTE, 0, 0, 0, 0, 32'h0);
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        run_phase(1, 1, 1, 1, 1, 1, 0, 0);
        small_phase();
        run_phase(32, 32, 1, 2, 5, 2, 4, 1);
        small_phase();
        odd_layer_phase();
        run_phase(5, 4, 8, 8, 1, 3, 0, 1);
        small_phase();
        odd_layer_phase();
        run_phase(32, 32, 1, 1, 3, 1, 0, 0);
        small_phase();
        odd_layer_phase();
        small_phase();
        quiet = 1'b1;
        small_phase();
        wait_idle();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_sums.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/c2le_pkg.sv
rtl/core/c2le_ctrl.sv
rtl/core/c2le_datapath.sv
rtl/core/conv2d_layer_engine_unit.sv
sim/conv2d_layer_engine_unit_tb.sv
